@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion helpers shared by the rtl files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MDF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication, checked outside reset
`define MDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

@@ sv/mdf_pkg.sv @@
// ---------------------------------------------------------------------------
// mdf_pkg
// types and constants of the message deframer
// ---------------------------------------------------------------------------
package mdf_pkg;

   localparam int unsigned HDR_SHORT = 20;
   localparam int unsigned HDR_LONG  = 24;
   localparam int unsigned WIN_BYTES = 4;
   localparam int unsigned POS_W     = 5;
   localparam int unsigned DATA_W    = 160;

   localparam logic [31:0] MAGIC_A    = 32'h0ABC_DEF0;
   localparam logic [31:0] MAGIC_B    = 32'h0FED_CBA0;
   localparam logic [15:0] CLASS_EXT  = 16'h6414;
   localparam logic [15:0] CLASS_ZERO = 16'h0000;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_BODY   = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'b001,
      PH_GATHER = 3'b010,
      PH_BODY   = 3'b100
   } phase_type;

   typedef logic [HDR_LONG-1:0][7:0] hdr_bytes_type;

   typedef struct packed {
      logic [31:0] message_id;
      logic [7:0]  channel_number;
      logic [15:0] message_number;
      logic [15:0] status_code;
      logic [15:0] message_class;
      logic [31:0] payload_offset;
      logic [31:0] body_length;
      logic        is_long;
   } hdr_fields_type;

endpackage

@@ sv/mdf_fields.sv @@
// ---------------------------------------------------------------------------
// mdf_fields
// unpacks little-endian header bytes into fields and sizes the header
// ---------------------------------------------------------------------------
module mdf_fields (
   input  mdf_pkg::hdr_bytes_type  hdr_i,
   output mdf_pkg::hdr_fields_type fields_o
);
   import mdf_pkg::*;

   logic [15:0] cls;
   logic        is_long;

   assign cls     = {hdr_i[19], hdr_i[18]};
   assign is_long = (cls == CLASS_EXT) || (cls == CLASS_ZERO);

   always_comb begin
      fields_o.message_id     = {hdr_i[7], hdr_i[6], hdr_i[5], hdr_i[4]};
      fields_o.body_length    = {hdr_i[11], hdr_i[10], hdr_i[9], hdr_i[8]};
      fields_o.channel_number = hdr_i[12];
      fields_o.message_number = {hdr_i[15], hdr_i[14]};
      fields_o.status_code    = {hdr_i[17], hdr_i[16]};
      fields_o.message_class  = cls;
      fields_o.is_long        = is_long;
      // offset bytes exist only in the long header form
      fields_o.payload_offset = is_long ? {hdr_i[23], hdr_i[22], hdr_i[21], hdr_i[20]}
                                        : 32'd0;
   end

endmodule

@@ sv/message_deframer.sv @@
// ---------------------------------------------------------------------------
// message_deframer
// hunts for a magic word, gathers a 20 or 24 byte header, then streams body
// ---------------------------------------------------------------------------
// result: held in the output register from the cycle after its byte is accepted
// throughput: one byte per cycle, set by the single input-to-result stage;
//   the input stalls only while an unread result blocks the output register
// reset: synchronous, clears phase to hunting, window count, remaining body count and output valid
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module message_deframer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,  // [7:0] rx_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [31:0] message_id, [39:32] channel_number, [55:40] message_number,
   // [71:56] status_code, [87:72] message_class, [119:88] payload_offset,
   // [151:120] body_length, [159:152] body_byte
   output logic [mdf_pkg::DATA_W-1:0]  rsp_tdata,
   output logic                        rsp_tuser,  // [0] item_kind
   output logic                        rsp_tlast   // message_end
);
   import mdf_pkg::*;

   localparam logic [POS_W-1:0] POS_WIN        = POS_W'(WIN_BYTES);
   localparam logic [POS_W-1:0] POS_LAST_SHORT = POS_W'(HDR_SHORT - 1);
   localparam logic [POS_W-1:0] POS_LAST_LONG  = POS_W'(HDR_LONG - 1);

   phase_type              phase_ff, phase_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   hdr_bytes_type          store_ff, store_in;
   logic [31:0]            remain_ff, remain_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic                   emit;
   logic [7:0]             rx_byte;
   logic [31:0]            window;
   hdr_bytes_type          hdr_view;
   hdr_fields_type         fields;

   assign rx_byte    = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // header as it stands with the arriving byte placed at its position
   always_comb begin
      hdr_view = store_ff;
      for (int i = 0; i < HDR_LONG; i++) begin
         if (pos_ff == POS_W'(i)) begin
            hdr_view[i] = rx_byte;
         end
      end
   end

   mdf_fields u_fields (
      .hdr_i    (hdr_view),
      .fields_o (fields)
   );

   assign window = {rx_byte, store_ff[3], store_ff[2], store_ff[1]};

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      store_in    = store_ff;
      remain_in   = remain_ff;
      emit        = 1'b0;
      rsp_kind_in = KIND_HEADER;
      rsp_last_in = 1'b0;
      rsp_data_in = '0;

      unique case (phase_ff)
         PH_GATHER: begin
            store_in = hdr_view;
            pos_in   = pos_ff + 1'b1;
            if ((pos_ff == POS_LAST_SHORT && !fields.is_long) ||
                pos_ff == POS_LAST_LONG) begin
               emit        = 1'b1;
               rsp_data_in = {8'd0, fields.body_length, fields.payload_offset,
                              fields.message_class, fields.status_code,
                              fields.message_number, fields.channel_number,
                              fields.message_id};
               remain_in   = fields.body_length;
               pos_in      = '0;
               if (fields.body_length == 32'd0) begin
                  rsp_last_in = 1'b1;
                  phase_in    = PH_HUNT;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            emit        = 1'b1;
            rsp_kind_in = KIND_BODY;
            rsp_data_in = {rx_byte, 152'd0};
            remain_in   = remain_ff - 1'b1;
            if (remain_ff == 32'd1) begin
               rsp_last_in = 1'b1;
               phase_in    = PH_HUNT;
               pos_in      = '0;
            end
         end
         PH_HUNT: begin
            store_in[0] = store_ff[1];
            store_in[1] = store_ff[2];
            store_in[2] = store_ff[3];
            store_in[3] = rx_byte;
            if (pos_ff < POS_WIN) begin
               pos_in = pos_ff + 1'b1;
            end
            // window full once this byte lands
            if (pos_ff >= POS_WIN - 1'b1 && (window == MAGIC_A || window == MAGIC_B)) begin
               phase_in = PH_GATHER;
               pos_in   = POS_WIN;
            end
         end
         default: begin
            phase_in    = PH_HUNT;
            store_in[3] = rx_byte;
            pos_in      = POS_W'(1);
         end
      endcase
   end

   assign rsp_valid_in = accept ? emit : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         pos_ff       <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            remain_ff <= remain_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff <= store_in;
      end
      if (accept && emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `MDF_ASSERT_IMPLY(a_body_count, clock, reset, phase_ff == PH_BODY, remain_ff != 32'd0)
   `MDF_ASSERT_IMPLY(a_gather_pos, clock, reset, phase_ff == PH_GATHER,
                     pos_ff >= POS_WIN && pos_ff <= POS_LAST_LONG)
   `MDF_ASSERT_IMPLY(a_hunt_pos, clock, reset, phase_ff == PH_HUNT, pos_ff <= POS_WIN)
   `MDF_ASSERT_IMPLY(a_open_header, clock, reset,
                     rsp_valid_ff && rsp_kind_ff == KIND_HEADER && !rsp_last_ff,
                     phase_ff == PH_BODY)
   `MDF_ASSERT_NEXT(a_no_emit_hunt, clock, reset,
                    !rsp_valid_ff && phase_ff == PH_HUNT, !rsp_valid_ff)

endmodule
